>>> design/tdpwq_pkg.sv
// Shared types, constants and codes of the task dispatcher.
package tdpwq_pkg;
   localparam int NumWorkersDefault = 8;
   localparam int QueueDepthDefault = 1024;
   localparam int OpW = 1;
   localparam int WidW = 3;
   localparam int DataW = 32;
   localparam int StatusW = 2;
   localparam int LenW = 11;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 4;

   typedef enum logic [OpW-1:0] {
      OP_SUBMIT = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_INACTIVE = 2'd3
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ACTIVE = 1'b0,
      CSR_POLICY = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   typedef struct packed {
      logic [WidW-1:0]  worker;
      logic [OpW-1:0]   op;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [WidW-1:0]    chosen;
      logic [LenW-1:0]    len;
   } rsp_type;
endpackage

>>> design/tdpwq_if.sv
// Valid and ready channel interfaces of the task dispatcher.
interface tdpwq_req_if import tdpwq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OpW-1:0]    op;
   logic [WidW-1:0]   worker_id;
   logic [DataW-1:0]  task_code;
   logic [DataW-1:0]  task_arg;
   modport source (output valid, op, worker_id, task_code, task_arg, input ready);
   modport sink (input valid, op, worker_id, task_code, task_arg, output ready);
endinterface

interface tdpwq_rsp_if import tdpwq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [StatusW-1:0] status;
   logic [WidW-1:0]    chosen_worker;
   logic [DataW-1:0]   out_code;
   logic [DataW-1:0]   out_arg;
   logic [LenW-1:0]    queue_length;
   modport source (output valid, status, chosen_worker, out_code, out_arg, queue_length,
                   input ready);
   modport sink (input valid, status, chosen_worker, out_code, out_arg, queue_length,
                 output ready);
endinterface

interface tdpwq_csr_if import tdpwq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/task_dispatcher_per_worker_queues.sv
// Top level of the task dispatcher with one ring queue per worker.
// channel | role   | carries
// req     | sink   | op, worker_id, task_code, task_arg
// rsp     | source | status, chosen_worker, out_code, out_arg, queue_length
// csr     | sink   | index, data (active_workers, policy)
// Each item passes through the states in order: idle accepts it, exec chooses the worker through
// the chain of worker cells and does the store access, and out holds the registered read data.
// The result register holds while rsp is stalled; the next item is accepted once it is taken.
// Reset is synchronous and resets pointers, the round robin state and the control registers.
module task_dispatcher_per_worker_queues import tdpwq_pkg::*; #(
   parameter int NumWorkers = NumWorkersDefault,
   parameter int QueueDepth = QueueDepthDefault
) (
   input logic clock,
   input logic reset,
   tdpwq_req_if.sink   req,
   tdpwq_rsp_if.source rsp,
   tdpwq_csr_if.sink   csr
);
   localparam int IdxW = (NumWorkers > 1) ? $clog2(NumWorkers) : 1;
   localparam int RW = IdxW + 1;
   localparam int SW = $clog2(QueueDepth);
   localparam int PW = SW + 1;
   localparam int AW = $clog2(NumWorkers * QueueDepth);

   state_type state_ff, state_in;
   logic [CsrDataW-1:0] active_ff;
   logic policy_ff;
   logic [IdxW-1:0] rr_ff, rr_in;
   logic [RW-1:0] rr_sum;
   logic rr_vld_ff;
   logic [OpW-1:0] op_ff;
   logic [WidW-1:0] wid_ff;
   logic [DataW-1:0] code_ff, arg_ff;
   rsp_type res_ff, res_in;
   logic pop_done_ff;

   logic [PW-1:0] chain_len [NumWorkers+1];
   logic [IdxW-1:0] chain_idx [NumWorkers+1];
   logic chain_vld [NumWorkers+1];
   logic [PW-1:0] lens [NumWorkers];
   logic [SW-1:0] wslots [NumWorkers], rslots [NumWorkers];
   logic [NumWorkers-1:0] push, pop, act;

   logic [CsrDataW-1:0] ncount;
   logic [IdxW-1:0] target;
   logic [PW-1:0] tlen;
   logic do_push, do_pop, wid_ok;
   logic [AW-1:0] addr, addr_in, addr_ff;
   logic [DataW-1:0] rd_code, rd_arg;

   assign ncount = (active_ff == '0) ? CsrDataW'(1) :
                   ((32'(active_ff) > NumWorkers) ? CsrDataW'(NumWorkers) : active_ff);

   assign chain_len[0] = '0;
   assign chain_idx[0] = '0;
   assign chain_vld[0] = 1'b0;

   for (genvar i = 0; i < NumWorkers; i++) begin : g_cell
      assign act[i] = 32'(i) < 32'(ncount);
      tdpwq_cell #(.Index(i), .QueueDepth(QueueDepth), .IdxW(IdxW)) u_cell (
         .clock, .reset, .active(act[i]), .push(push[i]), .pop(pop[i]),
         .best_len_in(chain_len[i]), .best_idx_in(chain_idx[i]),
         .best_vld_in(chain_vld[i]), .best_len_out(chain_len[i+1]),
         .best_idx_out(chain_idx[i+1]), .best_vld_out(chain_vld[i+1]),
         .len(lens[i]), .wr_slot(wslots[i]), .rd_slot(rslots[i]));
   end

   // The next pick is the last one plus one, reduced modulo the active count by
   // compare and subtract of shifted copies of the count.
   always_comb begin
      rr_sum = RW'(rr_ff) + RW'(1);
      for (int k = IdxW; k >= 0; k--) begin
         if (32'(rr_sum) >= (32'(ncount) << k)) begin
            rr_sum = rr_sum - RW'(32'(ncount) << k);
         end
      end
      rr_in = rr_vld_ff ? IdxW'(rr_sum) : '0;
   end

   assign target = (op_ff == OP_TAKE) ? IdxW'(wid_ff) :
                   (policy_ff ? chain_idx[NumWorkers] : rr_in);
   assign wid_ok = 32'(wid_ff) < 32'(ncount);
   assign tlen = lens[target];
   assign do_push = (state_ff == S_EXEC) && (op_ff == OP_SUBMIT) && (32'(tlen) < QueueDepth);
   assign do_pop = (state_ff == S_EXEC) && (op_ff == OP_TAKE) && wid_ok && (tlen != '0);
   assign addr_in = AW'(32'(target) * QueueDepth
                        + 32'(do_pop ? rslots[target] : wslots[target]));
   assign addr = (state_ff == S_EXEC) ? addr_in : addr_ff;

   always_comb begin
      push = '0;
      pop = '0;
      push[target] = do_push;
      pop[target] = do_pop;
   end

   tdpwq_ram #(.Width(DataW), .Depth(NumWorkers * QueueDepth)) u_code (
      .clock, .we(do_push), .addr(addr), .wdata(code_ff), .rdata(rd_code));
   tdpwq_ram #(.Width(DataW), .Depth(NumWorkers * QueueDepth)) u_arg (
      .clock, .we(do_push), .addr(addr), .wdata(arg_ff), .rdata(rd_arg));

   always_comb begin
      res_in.chosen = WidW'(target);
      res_in.len = LenW'(tlen);
      res_in.status = ST_DONE;
      if (op_ff == OP_SUBMIT) begin
         if (do_push) begin
            res_in.len = LenW'(tlen + PW'(1));
         end else begin
            res_in.status = ST_FULL;
         end
      end else if (!wid_ok) begin
         res_in.status = ST_INACTIVE;
         res_in.chosen = wid_ff;
         res_in.len = '0;
      end else if (tlen == '0) begin
         res_in.status = ST_EMPTY;
      end else begin
         res_in.len = LenW'(tlen - PW'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.status = res_ff.status;
   assign rsp.chosen_worker = res_ff.chosen;
   assign rsp.queue_length = res_ff.len;
   assign rsp.out_code = pop_done_ff ? rd_code : '0;
   assign rsp.out_arg = pop_done_ff ? rd_arg : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= CsrDataW'(1);
         policy_ff <= 1'b0;
         rr_ff <= '0;
         rr_vld_ff <= 1'b0;
         pop_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            unique case (csr_idx_type'(csr.index))
               CSR_ACTIVE: active_ff <= csr.data;
               CSR_POLICY: policy_ff <= csr.data[0];
               default: ;
            endcase
         end
         if (state_ff == S_EXEC) begin
            pop_done_ff <= do_pop;
            if (op_ff == OP_SUBMIT && !policy_ff) begin
               rr_ff <= rr_in;
               rr_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff <= req.op;
         wid_ff <= req.worker_id;
         code_ff <= req.task_code;
         arg_ff <= req.task_arg;
      end
      if (state_ff == S_EXEC) begin
         res_ff <= res_in;
         addr_ff <= addr_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_both: assert property (@(posedge clock) disable iff (reset) !(do_push && do_pop))
      else $error("push and pop together");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> rsp.valid)
      else $error("result missing after execute");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (32'(rsp.queue_length) <= QueueDepth))
      else $error("queue length beyond depth");
`endif
endmodule

>>> design/tdpwq_ram.sv
// Generic single-port RAM with registered read.
module tdpwq_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> design/tdpwq_cell.sv
// One worker cell: queue pointers and a running least-load comparison.
module tdpwq_cell import tdpwq_pkg::*; #(
   parameter int Index = 0,
   parameter int QueueDepth = 1024,
   parameter int IdxW = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          active,
   input  logic                          push,
   input  logic                          pop,
   input  logic [$clog2(QueueDepth):0]   best_len_in,
   input  logic [IdxW-1:0]               best_idx_in,
   input  logic                          best_vld_in,
   output logic [$clog2(QueueDepth):0]   best_len_out,
   output logic [IdxW-1:0]               best_idx_out,
   output logic                          best_vld_out,
   output logic [$clog2(QueueDepth):0]   len,
   output logic [$clog2(QueueDepth)-1:0] wr_slot,
   output logic [$clog2(QueueDepth)-1:0] rd_slot
);
   localparam int PW = $clog2(QueueDepth) + 1;
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;

   assign len = wp_ff - rp_ff;
   assign wr_slot = wp_ff[PW-2:0];
   assign rd_slot = rp_ff[PW-2:0];

   always_comb begin
      wp_in = push ? wp_ff + PW'(1) : wp_ff;
      rp_in = pop ? rp_ff + PW'(1) : rp_ff;
      if (active && (!best_vld_in || len < best_len_in)) begin
         best_len_out = len;
         best_idx_out = IdxW'(Index);
         best_vld_out = 1'b1;
      end else begin
         best_len_out = best_len_in;
         best_idx_out = best_idx_in;
         best_vld_out = best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule
